// File: rtl/three_phase_sweep_setpoint_ramp_defines.svh
// Assertion macros used by the sweep setpoint ramp top level.
`ifndef THREE_PHASE_SWEEP_SETPOINT_RAMP_DEFINES_SVH
`define THREE_PHASE_SWEEP_SETPOINT_RAMP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPSR_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TPSR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tpsr_pkg.sv
// Types, codes and constants of the sweep setpoint ramp.
`default_nettype none

package tpsr_pkg;

  localparam int ANGLE_FIELD_W = 12;
  localparam int STEP_W        = 8;
  localparam int OP_W          = 2;
  localparam int STEP_NUM_W    = 16;
  localparam int PROG_W        = 10;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 12;
  localparam int SPAN_W        = 12;
  localparam int TOTAL_W       = 14;

  localparam int DEF_ANGLE_WIDTH = 13;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam logic [PROG_W-1:0] PROG_FULL = 10'd1000;

  // operation codes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_START = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_STOP  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_STEP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_STEP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE   = 3'd5;

  // register reset values
  localparam logic signed [ANGLE_FIELD_W-1:0] RST_SWEEP_START = -12'sd750;
  localparam logic signed [ANGLE_FIELD_W-1:0] RST_SWEEP_STOP  = -12'sd1250;
  localparam logic signed [ANGLE_FIELD_W-1:0] RST_HOME        = 12'sd0;
  localparam logic [STEP_W-1:0] RST_FAST_STEP = 8'd30;
  localparam logic [STEP_W-1:0] RST_SLOW_STEP = 8'd3;
  localparam logic [STEP_W-1:0] RST_TOLERANCE = 8'd5;

  typedef enum logic [1:0] {
    KIND_STEP   = 2'd0,
    KIND_SNAP   = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LEG_GO     = 2'd0,
    LEG_SWEEP  = 2'd1,
    LEG_RETURN = 2'd2,
    LEG_IDLE   = 2'd3
  } leg_t;

  // what the shared divider works on
  typedef enum logic [1:0] {
    DIV_GO_LEG     = 2'd0,
    DIV_SWEEP_LEG  = 2'd1,
    DIV_RETURN_LEG = 2'd2,
    DIV_PROGRESS   = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic signed [ANGLE_FIELD_W-1:0] sweep_start;
    logic signed [ANGLE_FIELD_W-1:0] sweep_stop;
    logic signed [ANGLE_FIELD_W-1:0] home;
    logic [STEP_W-1:0]               fast_step;
    logic [STEP_W-1:0]               slow_step;
    logic [STEP_W-1:0]               tolerance;
  } cfg_t;

  typedef struct packed {
    logic     latch;
    logic     start_load;
    logic     total_acc;
    logic     exp_load;
    logic     snap;
    logic     step;
    logic     div_start;
    div_sel_t div_sel;
    logic     prog_load;
    logic     emit;
    kind_t    kind;
    leg_t     leg;
    leg_t     out_leg;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            near;
    logic            div_busy;
    logic            div_done;
    logic            out_free;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/tpsr_stream_if.sv
// Valid/ready channels for operation items and result beats.
`default_nettype none

interface tpsr_in_if;
  import tpsr_pkg::*;
  logic                            valid;
  logic                            ready;
  logic [OP_W-1:0]                 operation;
  logic signed [ANGLE_FIELD_W-1:0] measured_angle;
  modport source (output valid, operation, measured_angle, input ready);
  modport sink   (input valid, operation, measured_angle, output ready);
endinterface

interface tpsr_out_if;
  import tpsr_pkg::*;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      result_kind;
  logic signed [ANGLE_FIELD_W-1:0] setpoint_angle;
  logic [1:0]                      leg;
  logic [STEP_NUM_W-1:0]           step_number;
  logic [PROG_W-1:0]               progress;
  logic signed [ANGLE_FIELD_W-1:0] actual_angle;
  logic                            last_result;
  modport source (output valid, result_kind, setpoint_angle, leg, step_number, progress,
                  actual_angle, last_result, input ready);
  modport sink   (input valid, result_kind, setpoint_angle, leg, step_number, progress,
                  actual_angle, last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/tpsr_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module tpsr_divider #(
  parameter int DIVIDEND_W = 26,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  assign trial     = {rem, quo[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign fits      = trial >= {1'b0, dsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: rtl/tpsr_datapath.sv
// Setpoint, step counters, progress cache and the result register.
`default_nettype none

module tpsr_datapath #(
  parameter int ANGLE_WIDTH = 13,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  tpsr_pkg::cfg_t                            cfg,
  input  tpsr_pkg::cmd_t                            cmd,
  output tpsr_pkg::status_t                         status,
  input  logic [tpsr_pkg::OP_W-1:0]                 op_in,
  input  logic signed [tpsr_pkg::ANGLE_FIELD_W-1:0] angle_in,
  tpsr_out_if.source                                results
);
  import tpsr_pkg::*;

  // wide enough for any setpoint, any target and their difference
  localparam int WW    = ((ANGLE_WIDTH > ANGLE_FIELD_W) ? ANGLE_WIDTH : ANGLE_FIELD_W) + 2;
  localparam int DW    = COUNT_WIDTH + PROG_W;
  localparam int SAT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
  localparam int SN_W  = (COUNT_WIDTH > STEP_NUM_W) ? COUNT_WIDTH : STEP_NUM_W;

  function automatic logic [SPAN_W-1:0] span(input logic signed [ANGLE_FIELD_W-1:0] a,
                                             input logic signed [ANGLE_FIELD_W-1:0] b);
    logic signed [ANGLE_FIELD_W:0] d;
    d = {a[ANGLE_FIELD_W-1], a} - {b[ANGLE_FIELD_W-1], b};
    return d[ANGLE_FIELD_W] ? SPAN_W'(-d) : d[SPAN_W-1:0];
  endfunction

  logic [OP_W-1:0]                 op_q;
  logic signed [ANGLE_FIELD_W-1:0] actual_q;
  logic signed [ANGLE_WIDTH-1:0]   setpoint;
  logic signed [ANGLE_WIDTH-1:0]   setpoint_d;
  logic [COUNT_WIDTH-1:0]          steps_done;
  logic [COUNT_WIDTH-1:0]          steps_expected;
  logic [TOTAL_W-1:0]              total;
  logic [DW-1:0]                   prod;
  logic [PROG_W-1:0]               progress;

  logic signed [ANGLE_FIELD_W-1:0] target;
  logic [STEP_W-1:0]               step;
  logic [STEP_W-1:0]               fast_eff;
  logic [STEP_W-1:0]               slow_eff;
  logic signed [WW-1:0]            target_w;
  logic signed [WW-1:0]            sp_w;
  logic signed [WW-1:0]            actual_w;
  logic signed [WW-1:0]            diff;
  logic [WW-1:0]                   mag;
  logic                            up;
  logic signed [WW-1:0]            step_w;
  logic signed [WW-1:0]            sum;
  logic signed [WW-1:0]            clamped;
  logic signed [WW-1:0]            sp_out_w;
  logic [SAT_W-1:0]                total_ext;
  logic [COUNT_WIDTH-1:0]          total_sat;
  logic [SN_W-1:0]                 steps_ext;

  logic [DW-1:0]                   div_dividend;
  logic [COUNT_WIDTH-1:0]          div_divisor;
  logic [DW-1:0]                   div_quo;
  logic                            div_busy;
  logic                            div_done;

  logic                            out_valid;
  kind_t                           out_kind;
  logic signed [ANGLE_FIELD_W-1:0] out_setpoint;
  leg_t                            out_leg;
  logic [STEP_NUM_W-1:0]           out_steps;
  logic [PROG_W-1:0]               out_progress;
  logic signed [ANGLE_FIELD_W-1:0] out_actual;
  logic                            out_last;

  // a zero step size register acts as one
  assign fast_eff = (cfg.fast_step == '0) ? STEP_W'(1) : cfg.fast_step;
  assign slow_eff = (cfg.slow_step == '0) ? STEP_W'(1) : cfg.slow_step;

  always_comb begin
    unique case (cmd.leg)
      LEG_GO: begin
        target = cfg.sweep_start;
        step   = fast_eff;
      end
      LEG_SWEEP: begin
        target = cfg.sweep_stop;
        step   = slow_eff;
      end
      LEG_RETURN, LEG_IDLE: begin
        target = cfg.home;
        step   = fast_eff;
      end
    endcase
  end

  assign target_w = WW'(target);
  assign sp_w     = WW'(setpoint);
  assign actual_w = WW'(actual_q);
  assign diff     = target_w - sp_w;
  assign mag      = diff[WW-1] ? $unsigned(-diff) : $unsigned(diff);
  assign up       = !diff[WW-1] && (diff != '0);
  assign step_w   = $signed(WW'(step));
  assign sum      = up ? sp_w + step_w : sp_w - step_w;
  // never step past the target
  assign clamped  = up ? ((sum > target_w) ? target_w : sum)
                       : ((sum < target_w) ? target_w : sum);

  always_comb begin
    priority if (cmd.snap) setpoint_d = target_w[ANGLE_WIDTH-1:0];
    else if (cmd.step)     setpoint_d = clamped[ANGLE_WIDTH-1:0];
    else                   setpoint_d = setpoint;
  end

  assign sp_out_w  = WW'(setpoint_d);
  assign total_ext = SAT_W'(total);
  assign total_sat = (total_ext > SAT_W'({COUNT_WIDTH{1'b1}})) ? '1
                                                               : total_ext[COUNT_WIDTH-1:0];
  assign steps_ext = SN_W'(steps_done);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_GO_LEG: begin
        div_dividend = DW'(span(cfg.sweep_start, cfg.home));
        div_divisor  = COUNT_WIDTH'(fast_eff);
      end
      DIV_SWEEP_LEG: begin
        div_dividend = DW'(span(cfg.sweep_stop, cfg.sweep_start));
        div_divisor  = COUNT_WIDTH'(slow_eff);
      end
      DIV_RETURN_LEG: begin
        div_dividend = DW'(span(cfg.home, cfg.sweep_stop));
        div_divisor  = COUNT_WIDTH'(fast_eff);
      end
      DIV_PROGRESS: begin
        div_dividend = prod;
        div_divisor  = steps_expected;
      end
    endcase
  end

  tpsr_divider #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= op_in;
      actual_q <= angle_in;
    end
    prod <= DW'(steps_done) * DW'(PROG_FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      steps_done     <= '0;
      steps_expected <= '0;
      total          <= '0;
      progress       <= PROG_FULL;
    end else begin
      setpoint <= setpoint_d;
      if (cmd.start_load) begin
        setpoint   <= actual_w[ANGLE_WIDTH-1:0];
        steps_done <= '0;
        total      <= '0;
      end
      if (cmd.step && (steps_done != '1)) steps_done <= steps_done + 1'b1;
      if (cmd.total_acc) total <= total + TOTAL_W'(div_quo);
      if (cmd.exp_load) begin
        steps_expected <= total_sat;
        progress       <= (total_sat == '0) ? PROG_FULL : '0;
      end
      if (cmd.prog_load) begin
        priority if (steps_expected == '0)  progress <= PROG_FULL;
        else if (div_quo > DW'(PROG_FULL))  progress <= PROG_FULL;
        else                                progress <= div_quo[PROG_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind     <= cmd.kind;
      out_setpoint <= sp_out_w[ANGLE_FIELD_W-1:0];
      out_leg      <= cmd.out_leg;
      out_steps    <= steps_ext[STEP_NUM_W-1:0];
      out_progress <= progress;
      out_actual   <= actual_q;
      out_last     <= cmd.last;
    end
  end

  assign results.valid          = out_valid;
  assign results.result_kind    = out_kind;
  assign results.setpoint_angle = out_setpoint;
  assign results.leg            = out_leg;
  assign results.step_number    = out_steps;
  assign results.progress       = out_progress;
  assign results.actual_angle   = out_actual;
  assign results.last_result    = out_last;

  assign status.op       = op_q;
  assign status.near     = mag <= WW'(cfg.tolerance);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || results.ready;

endmodule

`default_nettype wire

// File: rtl/tpsr_ctrl.sv
// Sequencer: decodes items, walks the legs, runs the divider, issues beats.
`default_nettype none

module tpsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpsr_pkg::status_t status,
  output tpsr_pkg::cmd_t    cmd
);
  import tpsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EXPECT,
    S_EVAL,
    S_PMUL,
    S_EMIT_STEP,
    S_FINISH,
    S_CANCEL
  } state_t;

  state_t   state, state_next;
  leg_t     leg, leg_next;
  div_sel_t phase, phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.leg     = leg;
    cmd.out_leg = leg;
    cmd.div_sel = phase;
    cmd.kind    = KIND_STEP;
    state_next  = state;
    leg_next    = leg;
    phase_next  = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.op == OP_START) begin
          cmd.start_load = 1'b1;
          leg_next       = LEG_GO;
          phase_next     = DIV_GO_LEG;
          state_next     = S_DIV_GO;
        end else if (status.op == OP_CANCEL && leg != LEG_IDLE) begin
          state_next = S_CANCEL;
        end else if (status.op == OP_TICK && leg != LEG_IDLE) begin
          state_next = S_EVAL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          if (phase == DIV_PROGRESS) begin
            cmd.prog_load = 1'b1;
            state_next    = S_EMIT_STEP;
          end else begin
            cmd.total_acc = 1'b1;
            if (phase == DIV_RETURN_LEG) begin
              state_next = S_EXPECT;
            end else begin
              phase_next = div_sel_t'(phase + 2'd1);
              state_next = S_DIV_GO;
            end
          end
        end
      end
      S_EXPECT: begin
        cmd.exp_load = 1'b1;
        state_next   = S_IDLE;
      end
      S_EVAL: begin
        if (!status.near) begin
          cmd.step   = 1'b1;
          state_next = S_PMUL;
        end else if (status.out_free) begin
          cmd.snap = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = KIND_SNAP;
          if (leg == LEG_RETURN) begin
            leg_next   = LEG_IDLE;
            state_next = S_FINISH;
          end else begin
            leg_next = leg_t'(leg + 2'd1);
          end
        end
      end
      S_PMUL: begin
        phase_next = DIV_PROGRESS;
        state_next = S_DIV_GO;
      end
      S_EMIT_STEP: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_STEP;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_FINISH;
          cmd.out_leg = LEG_IDLE;
          cmd.last    = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_CANCEL;
          cmd.out_leg = LEG_IDLE;
          cmd.last    = 1'b1;
          leg_next    = LEG_IDLE;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      leg   <= LEG_IDLE;
      phase <= DIV_GO_LEG;
    end else begin
      state <= state_next;
      leg   <= leg_next;
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/three_phase_sweep_setpoint_ramp.sv
// Top level of the three-leg sweep setpoint ramp: register file, sequencer, datapath.
`default_nettype none

// Three-leg sweep setpoint ramp. Produces a position setpoint in tenths of a
// degree, one timer tick at a time. A start item (operation 0) loads the
// setpoint from measured_angle, clears the step count and works out the
// expected step total; it returns no beat. Each tick (operation 1) while a
// run is active snaps to the current leg target when within reach_tolerance
// (one snap beat, then the next leg is tried in the same tick) or takes one
// clamped step toward it (one step beat). The legs are: fast to
// sweep_start_angle, slow to sweep_stop_angle, fast back to home_angle.
// Snapping on the return leg is followed by a finished beat and the block
// goes idle. Cancel (operation 2) during a run gives one cancelled beat.
// Ticks and cancels while idle, and operation 3, are dropped silently. The
// last beat of each item has last_result set.
// Timing: one item at a time. ops.ready is high only while the sequencer
// waits for an item. Every division goes through one shared restoring
// divider that makes one quotient bit per cycle over COUNT_WIDTH+10 bits:
// a start runs the go, sweep and return leg divisions, and a tick that takes
// a step runs the progress division. A beat waiting in the result register
// does not hold off the next item; the sequencer only stalls when it must
// load a new beat and the previous one has not been taken.
// Registers are written through wr_en/wr_index/wr_data (indexes: 0 sweep
// start, 1 sweep stop, 2 home, 3 fast step, 4 slow step, 5 tolerance; other
// indexes are ignored) and are read live on every tick. A step size of zero
// acts as one.
module three_phase_sweep_setpoint_ramp #(
  parameter int ANGLE_WIDTH = tpsr_pkg::DEF_ANGLE_WIDTH,
  parameter int COUNT_WIDTH = tpsr_pkg::DEF_COUNT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  tpsr_in_if.sink                            ops,
  tpsr_out_if.source                         results,
  input  logic                               wr_en,
  input  logic [tpsr_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [tpsr_pkg::CFG_DATA_W-1:0]    wr_data
);
  import tpsr_pkg::*;

`include "three_phase_sweep_setpoint_ramp_defines.svh"

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_start <= RST_SWEEP_START;
      cfg.sweep_stop  <= RST_SWEEP_STOP;
      cfg.home        <= RST_HOME;
      cfg.fast_step   <= RST_FAST_STEP;
      cfg.slow_step   <= RST_SLOW_STEP;
      cfg.tolerance   <= RST_TOLERANCE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SWEEP_START: cfg.sweep_start <= wr_data;
        REG_SWEEP_STOP:  cfg.sweep_stop  <= wr_data;
        REG_HOME:        cfg.home        <= wr_data;
        REG_FAST_STEP:   cfg.fast_step   <= wr_data[STEP_W-1:0];
        REG_SLOW_STEP:   cfg.slow_step   <= wr_data[STEP_W-1:0];
        REG_TOLERANCE:   cfg.tolerance   <= wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign ops.ready = in_ready;

  // sequencer: owns the leg and run state
  tpsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ops.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // setpoint arithmetic, counters, divider and result register
  tpsr_datapath #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .op_in    (ops.operation),
    .angle_in (ops.measured_angle),
    .results  (results)
  );

  // a new beat never overwrites one that has not been taken
  `TPSR_ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit, status.out_free, "beat overwritten")
  // the divider is never restarted mid-division
  `TPSR_ASSERT_IMPL(a_div_idle, clk, rst, cmd.div_start, !status.div_busy, "divider restarted")
  // an accepted item keeps the input closed for at least the next cycle
  `TPSR_ASSERT_NEXT(a_busy_after_accept, clk, rst, ops.valid && ops.ready, !ops.ready, "item overlap")
  // progress stays saturated
  `TPSR_ASSERT_IMPL(a_progress_max, clk, rst, results.valid, results.progress <= PROG_FULL, "progress over limit")

endmodule

`default_nettype wire

// File: verif/tb_three_phase_sweep_setpoint_ramp.sv
// Self-checking testbench of the three-leg sweep setpoint ramp: directed and random beats.
`default_nettype none

module tb_three_phase_sweep_setpoint_ramp;
  import tpsr_pkg::*;

  // widths of the block's internal setpoint and counters, as built
  localparam int RAMP_ANGLE_W = DEF_ANGLE_WIDTH;
  localparam int RAMP_COUNT_W = DEF_COUNT_WIDTH;

  localparam int ANGLE_MAX     = 1800;
  localparam int SETTLE_CYCLES = 200;   // a start returns no beat
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 38;    // acted-on items per register setting
  localparam int RUN_TICK_CAP  = 200;
  localparam int SHOW_LIMIT    = 40;

  // operation code the block must drop
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // register indexes outside the map; the block ignores them
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

  // register settings the phases walk through
  typedef enum int {
    SET_WIDE_DOWN,   // angles at the extremes, largest steps, zero tolerance
    SET_UNIT_STEP,   // step sizes of zero, which act as one
    SET_ALL_SNAP,    // widest tolerance: up to four beats out of one tick
    SET_WIDE_UP,     // extremes the other way, unused indexes written too
    SET_RANDOM
  } setting_t;

  typedef struct {
    kind_t                           kind;
    logic signed [ANGLE_FIELD_W-1:0] setpoint;
    leg_t                            leg;
    logic [STEP_NUM_W-1:0]           step_num;
    logic [PROG_W-1:0]               progress;
    logic signed [ANGLE_FIELD_W-1:0] actual;
    logic                            last;
  } ramp_beat_t;

  // Tracks the ramp state, works out the beats each accepted item causes and
  // checks the beats coming out against them in order.
  class setpoint_tracker;
    logic signed [ANGLE_FIELD_W-1:0] start_ang, stop_ang, home_ang;
    logic [STEP_W-1:0]               fast_step, slow_step, tolerance;

    bit                              running;
    leg_t                            cur_leg;
    logic signed [RAMP_ANGLE_W-1:0]  setpt;
    logic [RAMP_COUNT_W-1:0]         steps_taken, steps_total;

    ramp_beat_t beats_due[$];
    int errors, beats_seen, shown;
    int kind_count[4];

    function new();
      start_ang   = RST_SWEEP_START;
      stop_ang    = RST_SWEEP_STOP;
      home_ang    = RST_HOME;
      fast_step   = RST_FAST_STEP;
      slow_step   = RST_SLOW_STEP;
      tolerance   = RST_TOLERANCE;
      running     = 1'b0;
      cur_leg     = LEG_IDLE;
      setpt       = '0;
      steps_taken = '0;
      steps_total = '0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SWEEP_START: start_ang = data;
        REG_SWEEP_STOP:  stop_ang  = data;
        REG_HOME:        home_ang  = data;
        REG_FAST_STEP:   fast_step = data[STEP_W-1:0];
        REG_SLOW_STEP:   slow_step = data[STEP_W-1:0];
        REG_TOLERANCE:   tolerance = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function int dist_of(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function logic [PROG_W-1:0] progress_now();
      longint unsigned p;
      if (steps_total == 0) return PROG_FULL;
      p = (64'(steps_taken) * 64'(PROG_FULL)) / 64'(steps_total);
      return (p > 64'(PROG_FULL)) ? PROG_FULL : p[PROG_W-1:0];
    endfunction

    function ramp_beat_t make_beat(kind_t kind, leg_t leg,
                                   logic signed [ANGLE_FIELD_W-1:0] ang);
      ramp_beat_t b;
      b.kind     = kind;
      b.setpoint = setpt[ANGLE_FIELD_W-1:0];
      b.leg      = leg;
      b.step_num = steps_taken;
      b.progress = progress_now();
      b.actual   = ang;
      b.last     = 1'b0;
      return b;
    endfunction

    // Returns 1 when the item did something (ignored items return 0).
    function bit note_item(logic [OP_W-1:0] op, logic signed [ANGLE_FIELD_W-1:0] ang);
      ramp_beat_t batch[$];
      int  fast, slow, target, stride, pos, total;
      bit  took;
      fast = (fast_step == 0) ? 1 : int'(fast_step);
      slow = (slow_step == 0) ? 1 : int'(slow_step);
      took = 1'b0;
      if (op == OP_START) begin
        total = dist_of(int'(start_ang), int'(home_ang)) / fast
              + dist_of(int'(stop_ang), int'(start_ang)) / slow
              + dist_of(int'(home_ang), int'(stop_ang)) / fast;
        steps_total = (total > int'({RAMP_COUNT_W{1'b1}})) ? '1 : total[RAMP_COUNT_W-1:0];
        steps_taken = '0;
        setpt       = ang;
        cur_leg     = LEG_GO;
        running     = 1'b1;
        took        = 1'b1;
      end else if (op == OP_CANCEL) begin
        if (running) begin
          running = 1'b0;
          cur_leg = LEG_IDLE;
          batch.push_back(make_beat(KIND_CANCEL, LEG_IDLE, ang));
          took = 1'b1;
        end
      end else if (op == OP_TICK && running) begin
        took = 1'b1;
        // snaps chain into the next leg; a step ends the tick
        while (running) begin
          case (cur_leg)
            LEG_GO: begin
              target = int'(start_ang);
              stride = fast;
            end
            LEG_SWEEP: begin
              target = int'(stop_ang);
              stride = slow;
            end
            default: begin
              target = int'(home_ang);
              stride = fast;
            end
          endcase
          pos = int'(setpt);
          if (dist_of(target, pos) <= int'(tolerance)) begin
            setpt = target[RAMP_ANGLE_W-1:0];
            batch.push_back(make_beat(KIND_SNAP, cur_leg, ang));
            if (cur_leg == LEG_GO) begin
              cur_leg = LEG_SWEEP;
            end else if (cur_leg == LEG_SWEEP) begin
              cur_leg = LEG_RETURN;
            end else begin
              cur_leg = LEG_IDLE;
              running = 1'b0;
              batch.push_back(make_beat(KIND_FINISH, LEG_IDLE, ang));
            end
          end else begin
            // clamp so the step never passes the target
            if (target > pos) pos = (pos + stride > target) ? target : pos + stride;
            else              pos = (pos - stride < target) ? target : pos - stride;
            setpt = pos[RAMP_ANGLE_W-1:0];
            if (steps_taken != '1) steps_taken++;
            batch.push_back(make_beat(KIND_STEP, cur_leg, ang));
            break;
          end
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) begin
        beats_due.push_back(batch[i]);
        kind_count[batch[i].kind]++;
      end
      return took;
    endfunction

    task report(string msg);
      errors++;
      if (shown < SHOW_LIMIT) begin
        $display("mismatch, beat %0d: %s", beats_seen, msg);
        shown++;
      end
    endtask

    task check_beat(ramp_beat_t got);
      ramp_beat_t want;
      beats_seen++;
      if (beats_due.size() == 0) begin
        report($sformatf("unexpected beat, kind %0d setpoint %0d", got.kind, got.setpoint));
        return;
      end
      want = beats_due.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
      if (got.setpoint !== want.setpoint)
        report($sformatf("setpoint_angle %0d, want %0d", got.setpoint, want.setpoint));
      if (got.leg !== want.leg)
        report($sformatf("leg %0d, want %0d", got.leg, want.leg));
      if (got.step_num !== want.step_num)
        report($sformatf("step_number %0d, want %0d", got.step_num, want.step_num));
      if (got.progress !== want.progress)
        report($sformatf("progress %0d, want %0d", got.progress, want.progress));
      if (got.actual !== want.actual)
        report($sformatf("actual_angle %0d, want %0d", got.actual, want.actual));
      if (got.last !== want.last)
        report($sformatf("last_result %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  tpsr_in_if  ops_if ();
  tpsr_out_if res_if ();

  three_phase_sweep_setpoint_ramp uut (
    .clk      (clk),
    .rst      (rst),
    .ops      (ops_if),
    .results  (res_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  setpoint_tracker tracker;

  bit calm;          // no idling on either side while set
  int items_sent;
  int useful;        // items the block acted on
  int settings;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Driving. All inputs change with nonblocking assignments right after a
  // rising edge; handshakes are sampled right after the edge, so what is read
  // is the value the block saw at that edge.
  // -------------------------------------------------------------------------

  // One input beat. valid stays high from the last beat when there is no gap,
  // so it is never dropped and raised in the same step.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [ANGLE_FIELD_W-1:0] ang);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      ops_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ops_if.valid          <= 1'b1;
    ops_if.operation      <= op;
    ops_if.measured_angle <= ang;
    @(posedge clk);
    while (!ops_if.ready) @(posedge clk);
    if (tracker.note_item(op, ang)) useful++;
    items_sent++;
  endtask

  // Stop sending and let every expected beat come out. Starts and dropped
  // items give no beat, so a fixed tail covers work still in flight.
  task automatic settle();
    int waited;
    waited = 0;
    ops_if.valid <= 1'b0;
    while (tracker.beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the 8-bit registers get junk in the unused top bits.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    if (idx >= REG_FAST_STEP) data[CFG_DATA_W-1:STEP_W] = $urandom_range(0, 15);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  function automatic int rand_angle();
    return int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
  endfunction

  // Any measured angle, the extremes a bit more often.
  function automatic logic signed [ANGLE_FIELD_W-1:0] any_angle();
    int a;
    case ($urandom_range(0, 19))
      0:       a = -ANGLE_MAX;
      1:       a = ANGLE_MAX;
      default: a = rand_angle();
    endcase
    return a[ANGLE_FIELD_W-1:0];
  endfunction

  // Start angle suited to the setting, so runs finish within the tick budget.
  function automatic logic signed [ANGLE_FIELD_W-1:0] pick_start(setting_t kind);
    int a;
    case (kind)
      SET_UNIT_STEP: a = int'($urandom_range(0, 30)) - 15;
      SET_ALL_SNAP: begin
        a = int'(tracker.start_ang) + int'($urandom_range(0, 800)) - 400;
        if (a > ANGLE_MAX)  a = ANGLE_MAX;
        if (a < -ANGLE_MAX) a = -ANGLE_MAX;
      end
      default: a = any_angle();
    endcase
    return a[ANGLE_FIELD_W-1:0];
  endfunction

  // Registers change only with the block idle and nothing outstanding.
  task automatic apply_setting(input setting_t kind);
    int s0, s1, s2, f, sl, tol;
    settle();
    case (kind)
      SET_WIDE_DOWN: begin
        s0 = ANGLE_MAX; s1 = -ANGLE_MAX; s2 = ANGLE_MAX; f = 255; sl = 255; tol = 0;
      end
      SET_UNIT_STEP: begin
        s0 = 8; s1 = -8; s2 = 0; f = 0; sl = 0; tol = 0;
      end
      SET_ALL_SNAP: begin
        s0 = 120; s1 = -90; s2 = 30; f = 255; sl = 255; tol = 255;
      end
      SET_WIDE_UP: begin
        s0 = -ANGLE_MAX; s1 = ANGLE_MAX; s2 = -ANGLE_MAX; f = 200; sl = 255; tol = 0;
      end
      default: begin
        s0  = rand_angle();
        s1  = rand_angle();
        s2  = rand_angle();
        f   = $urandom_range(100, 255);
        sl  = $urandom_range(60, 255);
        tol = $urandom_range(0, 60);
      end
    endcase
    write_reg(REG_SWEEP_START, s0);
    write_reg(REG_SWEEP_STOP,  s1);
    write_reg(REG_HOME,        s2);
    write_reg(REG_FAST_STEP,   f);
    write_reg(REG_SLOW_STEP,   sl);
    write_reg(REG_TOLERANCE,   tol);
    if (kind == SET_WIDE_UP) begin
      write_reg(REG_UNUSED_LO, $urandom_range(0, 4095));
      write_reg(REG_UNUSED_HI, $urandom_range(0, 4095));
    end
    wr_en <= 1'b0;
    settings++;
  endtask

  // A well-formed run: start, then ticks until the run ends, with the odd
  // cancel, restart or dropped code mixed in.
  task automatic run_sweep(input setting_t kind);
    int n, r;
    send_item(OP_START, pick_start(kind));
    n = 0;
    while (tracker.running && n < RUN_TICK_CAP) begin
      r = $urandom_range(0, 99);
      if (r < 3)      send_item(OP_CANCEL, any_angle());
      else if (r < 6) send_item(OP_START, pick_start(kind));
      else if (r < 8) send_item(OP_UNUSED, any_angle());
      else            send_item(OP_TICK, any_angle());
      n++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: draws a stall before each beat, then holds ready until a
  // beat is taken and checks it.
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    ramp_beat_t got;
    res_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got.kind     = kind_t'(res_if.result_kind);
      got.setpoint = res_if.setpoint_angle;
      got.leg      = leg_t'(res_if.leg);
      got.step_num = res_if.step_number;
      got.progress = res_if.progress;
      got.actual   = res_if.actual_angle;
      got.last     = res_if.last_result;
      tracker.check_beat(got);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus: directed beats on the reset settings, then phases of random
  // runs under several register settings, then the drain and the verdict.
  // -------------------------------------------------------------------------
  initial begin
    setting_t         kind;
    int               k, goal;
    logic [OP_W-1:0]  noise_op;
    tracker               = new();
    calm                  = 1'b0;
    wr_en                 = 1'b0;
    wr_index              = '0;
    wr_data               = '0;
    ops_if.valid          = 1'b0;
    ops_if.operation      = OP_START;
    ops_if.measured_angle = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle: tick, cancel and the unused code are all dropped
    send_item(OP_TICK,   12'sd0);
    send_item(OP_CANCEL, 12'sd1800);
    send_item(OP_UNUSED, -12'sd1800);
    // start near the first target: snap plus a sweep step in one tick
    send_item(OP_START,  -12'sd752);
    send_item(OP_TICK,   12'sd100);
    send_item(OP_TICK,   -12'sd5);
    send_item(OP_UNUSED, 12'sd7);
    send_item(OP_CANCEL, -12'sd33);
    // extreme start angles, and a restart while running
    send_item(OP_START,  12'sd1800);
    send_item(OP_TICK,   12'sd1800);
    send_item(OP_TICK,   -12'sd1800);
    send_item(OP_START,  -12'sd1800);
    send_item(OP_TICK,   12'sd1);
    send_item(OP_TICK,   -12'sd1);
    send_item(OP_CANCEL, -12'sd1800);
    // cancel before the first tick
    send_item(OP_START,  12'sd0);
    send_item(OP_CANCEL, 12'sd1800);
    send_item(OP_CANCEL, 12'sd0);

    for (k = 0; k < PHASES; k++) begin
      kind = (k < 4) ? setting_t'(k) : SET_RANDOM;
      apply_setting(kind);
      goal = useful + PHASE_ITEMS;
      while (useful < goal) begin
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 12) begin
          noise_op = $urandom_range(0, 3);
          send_item(noise_op, any_angle());
        end else begin
          run_sweep(kind);
        end
      end
    end

    calm = 1'b0;
    settle();
    if (tracker.beats_due.size() != 0)
      tracker.report($sformatf("%0d expected beats never came", tracker.beats_due.size()));

    $display("covered %0d items (%0d acted on) over %0d register settings after reset",
             items_sent, useful, settings);
    $display("checked %0d beats: %0d step, %0d snap, %0d finish, %0d cancel; %0d mismatches",
             tracker.beats_seen, tracker.kind_count[KIND_STEP], tracker.kind_count[KIND_SNAP],
             tracker.kind_count[KIND_FINISH], tracker.kind_count[KIND_CANCEL],
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("three_phase_sweep_setpoint_ramp regression: pass");
    end else begin
      $display("three_phase_sweep_setpoint_ramp regression: fail");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("timeout with %0d beats still expected", tracker.beats_due.size());
    $display("three_phase_sweep_setpoint_ramp regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
